// ===== hw/rtl/tjc_pkg.sv =====
// Shared types and constants for the timestamp jitter corrector.
// Used by tjc_cfg, tjc_ema and timestamp_jitter_corrector; no dependencies.
package tjc_pkg;

	localparam int TIME_W        = 64;
	localparam int DELTA_W       = 47;
	localparam int GAIN_W        = 16;
	localparam int CFG_INDEX_W   = 2;
	localparam int CFG_DATA_W    = 47;
	localparam int FRAC_BITS_DEF = 16;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd32768;

	localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_DELTA  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_DELTA_TOLERANCE = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_FILTER_GAIN     = 2'd2;

	typedef struct packed {
		logic [DELTA_W-1:0] expected_delta;
		logic [DELTA_W-1:0] delta_tolerance;
		logic [GAIN_W-1:0]  filter_gain;
	} tjc_cfg_t;

endpackage

// ===== hw/rtl/timestamp_jitter_corrector.sv =====
// A word accepted into the input register moves to the output register, which presents it.
// Throughput: one word per cycle while m_tready is high; feedback reaches the next word.
// While a result waits at the output, the input register still takes one more word.
// Reset (arst_n, asynchronous) clears valid bits, last time, estimate and first-word flag,
// and sets the registers to zero, zero and a gain of one half.
// Depends on tjc_pkg, tjc_cfg and tjc_ema.
module timestamp_jitter_corrector import tjc_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [TIME_W-1:0]      s_tdata,   // [63:0] time_in
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [TIME_W-1:0]      m_tdata,   // [63:0] time_out
	output logic [0:0]             m_tuser,   // [0] was_corrected
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	tjc_cfg_t cfg;

	logic              valid_s1;
	logic [TIME_W-1:0] time_s1;
	logic              valid_s2;
	logic [TIME_W-1:0] time_s2;
	logic              corrected_s2;

	logic              seen_first_q;
	logic [TIME_W-1:0] last_good_q;
	logic [TIME_W-1:0] estimate_q;

	logic              in_take;
	logic              advance;
	logic [TIME_W-1:0] expected;
	logic [TIME_W-1:0] tolerance;
	logic [TIME_W-1:0] delta;
	logic              in_window;
	logic              round_up;
	logic [TIME_W-1:0] predicted;
	logic [TIME_W-1:0] ema_next;
	logic [TIME_W-1:0] result;
	logic              corrected;
	logic [TIME_W-1:0] estimate_next;

	tjc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tjc_ema #(
		.FRAC_BITS (FRAC_BITS)
	) u_ema (
		.estimate      (estimate_q),
		.delta         (delta),
		.gain          (cfg.filter_gain),
		.estimate_next (ema_next)
	);

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || !valid_s2 || m_tready;
	assign in_take  = s_tvalid && s_tready;

	assign expected  = TIME_W'(cfg.expected_delta);
	assign tolerance = TIME_W'(cfg.delta_tolerance);
	assign delta     = time_s1 - last_good_q;
	// Ring distance between the observed and expected spacing.
	assign in_window = ((delta - expected) < tolerance) || ((expected - delta) < tolerance);

	assign round_up  = estimate_q[FRAC_BITS-1] && (|estimate_q[FRAC_BITS-2:0]);
	assign predicted = last_good_q + (estimate_q >> FRAC_BITS) + TIME_W'(round_up);

	always_comb begin
		priority if (!seen_first_q) begin
			result        = time_s1;
			corrected     = 1'b0;
			estimate_next = expected << FRAC_BITS;
		end else if (in_window) begin
			result        = time_s1;
			corrected     = 1'b0;
			estimate_next = ema_next;
		end else begin
			result        = predicted;
			corrected     = 1'b1;
			estimate_next = estimate_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			seen_first_q <= 1'b0;
			last_good_q  <= '0;
			estimate_q   <= '0;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2     <= 1'b1;
				seen_first_q <= 1'b1;
				last_good_q  <= result;
				estimate_q   <= estimate_next;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			time_s1 <= s_tdata;
		end
		if (advance) begin
			time_s2      <= result;
			corrected_s2 <= corrected;
		end
	end

	assign m_tvalid   = valid_s2;
	assign m_tdata    = time_s2;
	assign m_tuser[0] = corrected_s2;

`ifndef SYNTH
	a_corr_after_first: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && corrected_s2 |-> seen_first_q)
		else $error("corrected word before the first word was taken");

	a_first_sets_flag: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> seen_first_q && valid_s2)
		else $error("word left the input register without reaching the output");

	a_hold_input: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !m_tready |=> valid_s1 && $stable(time_s1))
		else $error("stalled input word was lost or overwritten");

	a_last_matches_out: assert property (@(posedge clk) disable iff (!arst_n)
		$past(advance) |-> last_good_q == time_s2)
		else $error("last good time differs from the word just produced");
`endif

endmodule

// ===== hw/rtl/tjc_cfg.sv =====
// Configuration register file of the timestamp jitter corrector.
// Depends on tjc_pkg for the register indexes and the tjc_cfg_t bundle.
module tjc_cfg import tjc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output tjc_cfg_t               cfg
);

	tjc_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_delta  <= '0;
			cfg_q.delta_tolerance <= '0;
			cfg_q.filter_gain     <= GAIN_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_EXPECTED_DELTA:  cfg_q.expected_delta  <= cfg_data[DELTA_W-1:0];
				REG_DELTA_TOLERANCE: cfg_q.delta_tolerance <= cfg_data[DELTA_W-1:0];
				REG_FILTER_GAIN:     cfg_q.filter_gain     <= cfg_data[GAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hw/rtl/tjc_ema.sv =====
// Exponential moving average update of the period estimate, with saturation.
// Depends on tjc_pkg for the word widths.
module tjc_ema import tjc_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic [TIME_W-1:0] estimate,
	input  logic [TIME_W-1:0] delta,
	input  logic [GAIN_W-1:0] gain,
	output logic [TIME_W-1:0] estimate_next
);

	localparam int KEEP_W = GAIN_W + 1;
	localparam int PA_W   = TIME_W + KEEP_W;
	localparam int PB_W   = TIME_W + GAIN_W;
	localparam int SUM_W  = TIME_W + GAIN_W + FRAC_BITS + 1;

	logic [KEEP_W-1:0] keep;
	logic [PA_W-1:0]   prod_a;
	logic [PB_W-1:0]   prod_b;
	logic [SUM_W-1:0]  sum;
	logic              sat;

	assign keep   = {1'b1, {GAIN_W{1'b0}}} - {1'b0, gain};
	assign prod_a = PA_W'(estimate) * PA_W'(keep);
	assign prod_b = PB_W'(delta) * PB_W'(gain);
	assign sum    = SUM_W'(prod_a) + (SUM_W'(prod_b) << FRAC_BITS);

	// The estimate saturates when the shifted sum no longer fits in a word.
	assign sat           = |sum[SUM_W-1:TIME_W+GAIN_W];
	assign estimate_next = sat ? {TIME_W{1'b1}} : sum[TIME_W+GAIN_W-1:GAIN_W];

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for timestamp_jitter_corrector: a stream of timestamps is driven in,
// each resulting word is predicted and checked against the output stream in order.
// Depends on tjc_pkg and the timestamp_jitter_corrector RTL.
module testbench import tjc_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = FRAC_BITS_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_WORDS = 100;
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
	localparam logic [63:0] DELTA_MASK = (64'd1 << DELTA_W) - 64'd1;

	typedef struct packed {
		logic [TIME_W-1:0] time_out;
		logic              was_corrected;
	} stamp_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [TIME_W-1:0]      s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [TIME_W-1:0]      m_tdata;
	logic [0:0]             m_tuser;
	logic                   cfg_wr_en = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	timestamp_jitter_corrector dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Corrector state as seen by the checker.
	logic [DELTA_W-1:0] cfg_expected = '0;
	logic [DELTA_W-1:0] cfg_tolerance = '0;
	logic [GAIN_W-1:0]  cfg_gain = GAIN_RESET;
	logic [TIME_W-1:0]  last_good = '0;
	logic [TIME_W-1:0]  est_fix = '0;
	logic               seen_first = 1'b0;

	logic [TIME_W-1:0] pending_stamps[$];
	stamp_result_t     expected_stamps[$];
	bit                word_taken = 1'b0;
	bit                no_idle = 1'b0;
	bit                hold_request = 1'b0;
	bit                hold_started = 1'b0;
	int                hold_left = 0;
	int                failures = 0;
	int                cycles = 0;
	stamp_result_t     oldest;

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic stamp_result_t correct_stamp(input logic [TIME_W-1:0] stamp);
		stamp_result_t     r;
		logic [TIME_W-1:0] delta;
		logic [TIME_W-1:0] exp64;
		logic [TIME_W-1:0] tol64;
		logic [127:0]      old_part;
		logic [127:0]      new_part;
		logic [127:0]      blend;
		r.was_corrected = 1'b0;
		r.time_out = stamp;
		if (!seen_first) begin
			est_fix = TIME_W'(cfg_expected) << FRAC;
			seen_first = 1'b1;
		end else begin
			delta = stamp - last_good;
			exp64 = TIME_W'(cfg_expected);
			tol64 = TIME_W'(cfg_tolerance);
			if ((delta - exp64) < tol64 || (exp64 - delta) < tol64) begin
				old_part = 128'(est_fix) * ((128'd1 << GAIN_W) - 128'(cfg_gain));
				new_part = (128'(delta) * 128'(cfg_gain)) << FRAC;
				blend = (old_part + new_part) >> GAIN_W;
				est_fix = (|blend[127:64]) ? '1 : blend[63:0];
			end else begin
				r.time_out = last_good + (est_fix >> FRAC)
					+ ((est_fix[FRAC-1:0] > (64'd1 << (FRAC - 1))) ? 64'd1 : 64'd0);
				r.was_corrected = 1'b1;
			end
		end
		last_good = r.time_out;
		return r;
	endfunction

	// Input side: every accepted word is predicted at once.
	always @(posedge clk) begin
		word_taken <= s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready)
			expected_stamps.push_back(correct_stamp(s_tdata));
	end

	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || word_taken)) begin
			if (pending_stamps.size() > 0 && (no_idle || $urandom_range(99) >= 26)) begin
				s_tdata <= pending_stamps.pop_front();
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_request && !hold_started) begin
			hold_started <= 1'b1;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= no_idle || ($urandom_range(99) >= 26);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_stamps.size() == 0) begin
				$error("unexpected word: time_out %h was_corrected %b", m_tdata, m_tuser[0]);
				failures++;
			end else begin
				oldest = expected_stamps.pop_front();
				if (m_tdata !== oldest.time_out) begin
					$error("time_out: expected %h, got %h", oldest.time_out, m_tdata);
					failures++;
				end
				if (m_tuser[0] !== oldest.was_corrected) begin
					$error("was_corrected: expected %b, got %b",
						oldest.was_corrected, m_tuser[0]);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic wait_idle();
		while (pending_stamps.size() > 0 || s_tvalid || expected_stamps.size() > 0)
			@(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[CFG_DATA_W-1:0];
		case (idx)
			REG_EXPECTED_DELTA:  cfg_expected = value[DELTA_W-1:0];
			REG_DELTA_TOLERANCE: cfg_tolerance = value[DELTA_W-1:0];
			REG_FILTER_GAIN:     cfg_gain = value[GAIN_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic set_all(input logic [63:0] exp_v, input logic [63:0] tol_v,
			input logic [63:0] gain_v);
		wait_idle();
		cfg_write(REG_EXPECTED_DELTA, exp_v);
		cfg_write(REG_DELTA_TOLERANCE, tol_v);
		cfg_write(REG_FILTER_GAIN, gain_v);
	endtask

	// Sent one at a time so that the offset is taken from the last good time.
	task automatic send_offset(input logic [63:0] offset);
		wait_idle();
		pending_stamps.push_back(last_good + offset);
	endtask

	initial begin
		logic [63:0] exp_v;
		logic [63:0] tol_v;
		logic [63:0] gain_v;
		logic [63:0] span;
		logic [63:0] nominal;
		logic [63:0] stamp;
		logic [63:0] prev_stamp;
		int          pick;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Half-unit fractions arise from a gain of one half; the first word wraps shortly after.
		cfg_write(REG_UNUSED, '1);
		set_all(64'd1000, 64'd50, 64'd32768);
		pending_stamps.push_back(64'hFFFF_FFFF_FFFF_F63C);
		send_offset(64'd1001);
		send_offset(64'd5000);
		send_offset(64'd1000);
		send_offset(64'd1001);
		send_offset(64'd0);
		send_offset(64'd1050);
		send_offset(64'd1049);
		send_offset(64'd951);
		send_offset(64'd950);
		send_offset(-64'd1);
		wait_idle();
		pending_stamps.push_back('1);
		wait_idle();
		pending_stamps.push_back('0);

		// A step backwards lies within the ring tolerance and saturates the estimate.
		set_all(64'd0, 64'd100, 64'd65535);
		send_offset(-64'd10);
		send_offset(64'd0);
		send_offset(64'd500);

		set_all(64'd1000, 64'd1000, 64'd0);
		send_offset(64'd1200);
		send_offset(64'd3000);
		wait_idle();
		cfg_write(REG_DELTA_TOLERANCE, 64'd0);
		send_offset(64'd1000);

		set_all(DELTA_MASK, DELTA_MASK, 64'd1);
		send_offset(DELTA_MASK + 64'd5);
		send_offset(64'd1 << 48);

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin
					exp_v = 64'($urandom_range(5000, 1));
					tol_v = 64'($urandom_range(32'(exp_v / 4 + 1), 1));
					gain_v = 64'($urandom_range(65535, 1));
				end
				1: begin
					exp_v = rand64() & DELTA_MASK;
					tol_v = exp_v >> $urandom_range(12, 2);
					gain_v = 64'd1;
				end
				2: begin
					exp_v = 64'($urandom_range(100000, 100));
					tol_v = exp_v / 10 + 1;
					gain_v = 64'd65535;
				end
				3: begin
					exp_v = {32'd0, $urandom};
					tol_v = exp_v >> 3;
					gain_v = 64'($urandom_range(65535, 1));
				end
				4: begin
					exp_v = 64'($urandom_range(1000, 1));
					tol_v = 64'($urandom_range(32'(exp_v), 0));
					gain_v = 64'($urandom_range(65535, 0));
				end
				default: begin
					exp_v = DELTA_MASK;
					tol_v = DELTA_MASK;
					gain_v = 64'($urandom_range(65535, 1));
				end
			endcase
			set_all(exp_v, tol_v, gain_v);
			wait_idle();
			if (phase == 2)
				hold_request = 1'b1;
			no_idle = (phase == 3);
			nominal = last_good;
			prev_stamp = last_good;
			span = tol_v + tol_v / 2;
			for (int i = 0; i < PHASE_WORDS; i++) begin
				if (phase == 4 && i == PHASE_WORDS / 2)
					wait_idle();
				pick = $urandom_range(99);
				if (pick < 78) begin
					nominal += exp_v;
					stamp = nominal + rand64() % (2 * span + 1) - span;
				end else if (pick < 86) begin
					nominal += 2 * exp_v;
					stamp = nominal + rand64() % (2 * span + 1) - span;
				end else if (pick < 92) begin
					stamp = prev_stamp;
				end else begin
					stamp = rand64();
				end
				pending_stamps.push_back(stamp);
				prev_stamp = stamp;
			end
		end

		wait_idle();
		no_idle = 1'b0;
		repeat (8) @(posedge clk);
		if (failures == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
